// File: hw/rtl/ookrx_pkg.sv
// Shared constants, codes and payload types for the OOK preamble and frame receiver.
package ookrx_pkg;

   // Ring of edge intervals used for preamble detection.
   localparam int WINDOW = 8;
   localparam int HALF   = WINDOW / 2;

   // Field widths.
   localparam int IVL_W  = 16;
   localparam int BYTE_W = 8;
   localparam int CNT_W  = 12;
   localparam int BIDX_W = CNT_W - 3;
   localparam int SUM_W  = 16;
   localparam int MODE_W = 2;

   // Receiver modes.
   localparam logic [MODE_W-1:0] MODE_HUNT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LEAD = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RECV = 2'd2;

   // Input function codes.
   localparam logic FUNC_EDGE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // Configuration register indexes and reset values.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_FIRST    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_SECOND   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECKSUM_SEED = 2'd2;
   localparam logic [BYTE_W-1:0] SYNC_FIRST_RST    = 8'hDF;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RST   = 8'h00;
   localparam logic [BYTE_W-1:0] CHECKSUM_SEED_RST = 8'h55;

   // Payload of one input transaction.
   typedef struct packed {
      logic             func;
      logic [IVL_W-1:0] interval;
      logic             pin_level;
   } req_payload_type;

   // Payload of one result transaction.
   typedef struct packed {
      logic              timer_load_valid;
      logic [IVL_W-1:0]  timer_load;
      logic              hunting;
      logic              byte_valid;
      logic [BYTE_W-1:0] data_byte;
      logic              frame_done;
      logic              frame_ok;
      logic [BYTE_W-1:0] payload_length;
   } rsp_payload_type;

endpackage

// File: hw/rtl/ookrx_if.sv
// Valid/ready channel interfaces for the receiver's input and result streams.
interface ookrx_req_if import ookrx_pkg::*; ;
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ookrx_rsp_if import ookrx_pkg::*; ;
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/ook_preamble_and_frame_receiver.sv
// Top level of the OOK preamble hunter and frame receiver.
//
//  Channel  Direction  Handshake          Contents
//  req_ch   in         valid/ready        func, interval, pin_level
//  rsp_ch   out        valid/ready        timer load, mode, payload byte, frame status
//  csr_*    in         write enable only  sync_first, sync_second, checksum_seed
//
// A transaction is held in the input register while the interval window compare and
// frame logic compute its result, which the result register then takes; rsp_ch.valid
// is driven from the result register. A new transaction can be accepted every cycle
// while the result channel is not stalled.
// Reset is synchronous and clears the interval window, the mode and all counters.
// A stalled result holds the processing stage; the input register still takes
// one transaction before req_ch.ready drops.
module ook_preamble_and_frame_receiver import ookrx_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   ookrx_req_if.sink            req_ch,
   ookrx_rsp_if.source          rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata
);

   // Configuration registers.
   logic [BYTE_W-1:0] sync_first_ff;
   logic [BYTE_W-1:0] sync_second_ff;
   logic [BYTE_W-1:0] seed_ff;

   // Input and result registers.
   logic            in_valid_ff;
   req_payload_type in_ff;
   logic            out_valid_ff;
   rsp_payload_type out_ff;
   rsp_payload_type out_in;
   logic            advance;

   // Receiver state.
   logic [IVL_W-1:0]  ring_ff [WINDOW];
   logic [IVL_W-1:0]  ring_in [WINDOW];
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [IVL_W-1:0]  period_ff, period_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0] shift_ff, shift_in;
   logic [BYTE_W-1:0] len_ff, len_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]  rsum_ff, rsum_in;

   // Window statistics.
   logic [IVL_W-1:0] nmin, nmax, omin, omax;
   logic             found;
   logic [IVL_W:0]   mid_sum;
   logic [IVL_W-1:0] new_period;
   logic [IVL_W+2:0] lead_prod;

   // Frame decode.
   logic [BIDX_W-1:0] bidx;
   logic [2:0]        bitpos;
   logic [BIDX_W-1:0] len_p3, len_p4, len_p6;
   logic [BYTE_W-1:0] shifted;
   logic              abort, finish;

   // Handshake: the processing stage moves when the result slot is free or emptied.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.data  = out_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RST;
         sync_second_ff <= SYNC_SECOND_RST;
         seed_ff        <= CHECKSUM_SEED_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SYNC_FIRST:    sync_first_ff  <= csr_wdata;
            CSR_SYNC_SECOND:   sync_second_ff <= csr_wdata;
            CSR_CHECKSUM_SEED: seed_ff        <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_ff <= req_ch.data;
      end
   end

   // Window with the new interval shifted in: tap 0 is the newest.
   always_comb begin
      ring_in[0] = in_ff.interval;
      for (int k = 1; k < WINDOW; k++) begin
         ring_in[k] = ring_ff[k-1];
      end
   end

   // Minimum and maximum of the newer and the older half.
   always_comb begin
      nmin = '1;
      nmax = '0;
      omin = '1;
      omax = '0;
      for (int k = 0; k < HALF; k++) begin
         if (ring_in[k] < nmin) nmin = ring_in[k];
         if (ring_in[k] > nmax) nmax = ring_in[k];
         if (ring_in[k+HALF] < omin) omin = ring_in[k+HALF];
         if (ring_in[k+HALF] > omax) omax = ring_in[k+HALF];
      end
   end

   // Preamble test: older half strictly between 0.4 and 0.8 of the newer half.
   assign found = (({3'b000, omax} + {1'b0, omax, 2'b00}) < {1'b0, nmin, 2'b00}) &&
                  (({3'b000, omin} + {1'b0, omin, 2'b00}) > {2'b00, nmax, 1'b0});
   assign mid_sum    = {1'b0, omin} + {1'b0, omax};
   assign new_period = mid_sum[IVL_W:1];
   assign lead_prod  = {3'b000, new_period} + {1'b0, new_period, 2'b00};

   // Bit position within the frame.
   assign bidx    = count_ff[CNT_W-1:3];
   assign bitpos  = count_ff[2:0];
   assign len_p3  = {1'b0, len_ff} + BIDX_W'(3);
   assign len_p4  = {1'b0, len_ff} + BIDX_W'(4);
   assign len_p6  = {1'b0, len_ff} + BIDX_W'(6);
   assign shifted = ((bitpos == 3'd0) ? '0 : shift_ff) |
                    (BYTE_W'(in_ff.pin_level) << bitpos);

   always_comb begin
      abort  = 1'b0;
      finish = 1'b0;
      if (bitpos == 3'd0 && bidx == BIDX_W'(1) && shift_ff != sync_first_ff) begin
         abort = 1'b1;
      end else if (bitpos == 3'd0 && bidx == BIDX_W'(2) && shift_ff != sync_second_ff) begin
         abort = 1'b1;
      end else if (bidx > BIDX_W'(2) && bidx == len_p6) begin
         finish = 1'b1;
      end
   end

   // Next state and result for the transaction in the input register.
   always_comb begin
      mode_in   = mode_ff;
      period_in = period_ff;
      count_in  = count_ff;
      shift_in  = shift_ff;
      len_in    = len_ff;
      sum_in    = sum_ff;
      rsum_in   = rsum_ff;
      out_in    = '0;
      if (in_ff.func == FUNC_EDGE) begin
         if (mode_ff == MODE_HUNT && found) begin
            period_in               = new_period;
            count_in                = '0;
            shift_in                = '0;
            len_in                  = '0;
            sum_in                  = {8'h00, seed_ff};
            rsum_in                 = '0;
            mode_in                 = MODE_LEAD;
            out_in.timer_load_valid = 1'b1;
            out_in.timer_load       = lead_prod[IVL_W+2:3];
         end
      end else begin
         case (mode_ff)
            MODE_LEAD: begin
               out_in.timer_load_valid = 1'b1;
               out_in.timer_load       = period_ff;
               count_in                = '0;
               mode_in                 = MODE_RECV;
            end
            MODE_RECV: begin
               if (abort || finish) begin
                  out_in.timer_load_valid = 1'b1;
                  out_in.frame_done       = 1'b1;
                  out_in.frame_ok         = finish && (rsum_ff == sum_ff);
                  mode_in                 = MODE_HUNT;
               end else begin
                  shift_in = shifted;
                  count_in = count_ff + CNT_W'(1);
                  if (bitpos == 3'd7) begin
                     if (bidx == BIDX_W'(2)) begin
                        len_in = shifted;
                     end else if (bidx >= BIDX_W'(3) && bidx < len_p3) begin
                        out_in.byte_valid = 1'b1;
                        out_in.data_byte  = shifted;
                        sum_in            = sum_ff + {8'h00, shifted};
                     end else if (bidx == len_p3) begin
                        rsum_in = {rsum_ff[15:8], shifted};
                     end else if (bidx == len_p4) begin
                        rsum_in = {shifted, rsum_ff[7:0]};
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      out_in.hunting        = (mode_in == MODE_HUNT);
      out_in.payload_length = len_in;
   end

   // State update on each processed transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WINDOW; k++) begin
            ring_ff[k] <= '0;
         end
         mode_ff   <= MODE_HUNT;
         period_ff <= '0;
         count_ff  <= '0;
         shift_ff  <= '0;
         len_ff    <= '0;
         sum_ff    <= '0;
         rsum_ff   <= '0;
      end else if (advance) begin
         if (in_ff.func == FUNC_EDGE && mode_ff == MODE_HUNT) begin
            ring_ff <= ring_in;
         end
         mode_ff   <= mode_in;
         period_ff <= period_in;
         count_ff  <= count_in;
         shift_ff  <= shift_in;
         len_ff    <= len_in;
         sum_ff    <= sum_in;
         rsum_ff   <= rsum_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   // A held result always reports the mode that the receiver is in.
   a_hunting_matches_mode: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.hunting == (mode_ff == MODE_HUNT)))
      else $error("result hunting flag disagrees with receiver mode");

   // Payload bytes are only reported while receiving a frame.
   a_byte_only_in_recv: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.byte_valid) |-> (mode_ff == MODE_RECV))
      else $error("payload byte reported outside frame reception");

   // A processed transaction always lands in the result register.
   a_advance_fills_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("processed transaction produced no result");

   // A transaction waiting in the input register is never dropped.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_ff)))
      else $error("waiting input transaction was lost");

endmodule
